/* sv/brmq_pkg.sv */
// Shared types and constants for the block ring message queue.
`default_nettype none
package brmq_pkg;

  localparam int LEN_W           = 16;
  localparam int BYTE_W          = 8;
  localparam int RLEN_W          = 14;
  localparam int USED_W          = 10;
  localparam int ACT_W           = 3;
  localparam int STATUS_W        = 3;
  localparam int CAPREG_W        = 10;
  localparam int LOG2REG_W       = 4;
  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 32;
  localparam int MAX_BLOCK_BYTES = 16384;
  localparam int LOG2_MIN_I      = 5;

  localparam logic [LOG2REG_W-1:0] LOG2_MIN   = 4'd5;
  localparam logic [LOG2REG_W-1:0] LOG2_MAX   = 4'd14;
  localparam logic [CAPREG_W-1:0]  CAP_RESET  = 10'd512;
  localparam logic [LOG2REG_W-1:0] LOG2_RESET = 4'd5;

  localparam logic [1:0] REG_CAPACITY   = 2'd0;
  localparam logic [1:0] REG_BLOCK_LOG2 = 2'd1;
  localparam logic [1:0] REG_OVERFLOW   = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_OPEN_SEND = 3'd0,
    ACT_SEND_BYTE = 3'd1,
    ACT_OPEN_RECV = 3'd2,
    ACT_RECV_BYTE = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_STOP      = 3'd5,
    ACT_RESUME    = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_TOO_LARGE = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_ABORTED   = 3'd4,
    STS_SEQ_ERR   = 3'd5,
    STS_OVERFLOW  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PMOD,
    S_LREAD,
    S_LDATA,
    S_QMOD,
    S_RBYTE,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t                 status;
    logic [BYTE_W-1:0]       read_byte;
    logic [RLEN_W-1:0]       read_length;
    logic                    last_byte;
    logic [USED_W-1:0]       used_blocks;
  } result_t;

endpackage
`default_nettype wire

/* sv/block_ring_message_queue.sv */
// Block ring message queue: top level with stream ports, APB registers and output register.
//
// Usage: each input item on the s_ stream carries an action in s_tuser and the
// message length and payload byte in s_tdata. Every item yields exactly one
// result item on the m_ stream: status in m_tuser, end of message on m_tlast,
// and read byte, read length and occupied block count in m_tdata.
// Items are handled one at a time. Open receive/receive byte bring data out
// of the ring and length memories, each through a registered read port.
// Clear, stop, resume, errors and plain send bytes finish in decode; an
// open send adds a write block reduction, a plain receive byte a ring
// read, an open receive a read block reduction and a length lookup. A
// send or receive that ends a message adds a length lookup and two block
// index reductions; a reduction is normally a quick subtract, but it runs
// bit-serially when an index reaches 2x the capacity after a capacity change.
// The next item is taken as soon as the result sits in the output register,
// so the result register parts the two sides. If m_tready stays low, one
// result waits there and the following item stalls once it is finished.
// Reset clears the queue pointers, counters and register defaults; memory
// contents are left undefined and need no clearing pass.
`default_nettype none
module block_ring_message_queue #(
  parameter int RING_BYTES   = 16384,
  parameter int MAX_BLOCKS   = 512,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [23:0]                      s_tdata,  // message_length, data_byte
  input  wire logic [2:0]                       s_tuser,  // action
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [31:0]                      m_tdata,  // read_byte, read_length, used_blocks
  output logic      [2:0]                       m_tuser,  // status
  output logic                                  m_tlast,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [brmq_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [brmq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [brmq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  localparam int END_W = $clog2(RING_BYTES + 1);
  localparam int CAP_W = $clog2(MAX_BLOCKS + 1);

  logic [CAP_W-1:0]                cap;
  logic [brmq_pkg::LOG2REG_W-1:0]  lg;
  logic [END_W-1:0]                ring_end;
  logic                            ovf_err;
  logic                            out_free;
  logic                            res_load;
  brmq_pkg::result_t               res;
  brmq_pkg::result_t               res_q;

  assign pready = 1'b1;

  brmq_regs #(
    .RING_BYTES(RING_BYTES),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cap     (cap),
    .lg      (lg),
    .ring_end(ring_end),
    .ovf_err (ovf_err)
  );

  brmq_core #(
    .RING_BYTES  (RING_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_action(brmq_pkg::action_t'(s_tuser)),
    .in_len   (s_tdata[15:0]),
    .in_byte  (s_tdata[23:16]),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .cap      (cap),
    .lg       (lg),
    .ring_end (ring_end),
    .ovf_err  (ovf_err)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (res_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) res_q <= res;
  end

  assign m_tdata = {res_q.used_blocks, res_q.read_length, res_q.read_byte};
  assign m_tuser = res_q.status;
  assign m_tlast = res_q.last_byte;

endmodule
`default_nettype wire

/* sv/brmq_regs.sv */
// APB register file and effective ring geometry.
`default_nettype none
module brmq_regs #(
  parameter int RING_BYTES = 16384,
  parameter int MAX_BLOCKS = 512,
  localparam int END_W = $clog2(RING_BYTES + 1),
  localparam int CAP_W = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [brmq_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [brmq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [brmq_pkg::APB_DATA_W-1:0]     prdata,
  output logic      [CAP_W-1:0]                    cap,
  output logic      [brmq_pkg::LOG2REG_W-1:0]      lg,
  output logic      [END_W-1:0]                    ring_end,
  output logic                                     ovf_err
);

  localparam int CW = (END_W > CAP_W) ? END_W : CAP_W;

  logic [brmq_pkg::CAPREG_W-1:0]  capacity;
  logic [brmq_pkg::LOG2REG_W-1:0] block_log2;
  logic                           overflow_is_error;
  logic                           wr_en;
  logic [END_W-1:0]               lim;
  logic [CW-1:0]                  c;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity          <= brmq_pkg::CAP_RESET;
      block_log2        <= brmq_pkg::LOG2_RESET;
      overflow_is_error <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        brmq_pkg::REG_CAPACITY:   capacity <= pwdata[brmq_pkg::CAPREG_W-1:0];
        brmq_pkg::REG_BLOCK_LOG2: block_log2 <= pwdata[brmq_pkg::LOG2REG_W-1:0];
        brmq_pkg::REG_OVERFLOW:   overflow_is_error <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      brmq_pkg::REG_CAPACITY:   prdata = brmq_pkg::APB_DATA_W'(capacity);
      brmq_pkg::REG_BLOCK_LOG2: prdata = brmq_pkg::APB_DATA_W'(block_log2);
      brmq_pkg::REG_OVERFLOW:   prdata = brmq_pkg::APB_DATA_W'(overflow_is_error);
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    lg = block_log2;
    if (lg < brmq_pkg::LOG2_MIN) lg = brmq_pkg::LOG2_MIN;
    if (lg > brmq_pkg::LOG2_MAX) lg = brmq_pkg::LOG2_MAX;
    lim = END_W'(RING_BYTES) >> lg;
    c = CW'(capacity);
    if (c > CW'(MAX_BLOCKS)) c = CW'(MAX_BLOCKS);
    if (c > CW'(lim)) c = CW'(lim);
    if (c == '0) c = CW'(1);
    cap = CAP_W'(c);
    ring_end = END_W'(cap) << lg;
  end

  assign ovf_err = overflow_is_error;

endmodule
`default_nettype wire

/* sv/brmq_mod.sv */
// Block index reduction modulo the capacity: quick subtract or bit-serial remainder.
`default_nettype none
module brmq_mod #(
  parameter int NUM_W = 13,
  parameter int CAP_W = 10,
  parameter int BLK_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] x,
  input  wire logic [CAP_W-1:0] d,
  output logic                  done,
  output logic      [BLK_W-1:0] r
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] xs;
  logic [CAP_W-1:0] rem;
  logic [NUM_W-1:0] dx;
  logic [NUM_W-1:0] xm;
  logic [CAP_W:0]   t;
  logic [CAP_W:0]   tr;

  always_comb begin
    dx = NUM_W'(d);
    xm = x - dx;
    t  = {rem, xs[NUM_W-1]};
    tr = (t >= {1'b0, d}) ? t - {1'b0, d} : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (x < dx) begin
          rem  <= CAP_W'(x);
          done <= 1'b1;
        end else if (xm < dx) begin
          rem  <= CAP_W'(xm);
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(NUM_W);
          xs   <= x;
          rem  <= '0;
        end
      end else if (busy) begin
        rem <= CAP_W'(tr);
        xs  <= xs << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign r = BLK_W'(rem);

endmodule
`default_nettype wire

/* sv/brmq_core.sv */
// Queue sequencer with the byte ring and block length memories.
`default_nettype none
module brmq_core #(
  parameter int RING_BYTES   = 16384,
  parameter int MAX_BLOCKS   = 512,
  parameter int HEADER_BYTES = 32,
  localparam int END_W = $clog2(RING_BYTES + 1),
  localparam int CAP_W = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire brmq_pkg::action_t                  in_action,
  input  wire logic [brmq_pkg::LEN_W-1:0]         in_len,
  input  wire logic [brmq_pkg::BYTE_W-1:0]        in_byte,
  input  wire logic                               out_free,
  output logic                                    res_load,
  output brmq_pkg::result_t                       res,
  input  wire logic [CAP_W-1:0]                   cap,
  input  wire logic [brmq_pkg::LOG2REG_W-1:0]     lg,
  input  wire logic [END_W-1:0]                   ring_end,
  input  wire logic                               ovf_err
);

  localparam int LEN_W = brmq_pkg::LEN_W;
  localparam int RA_W  = $clog2(RING_BYTES);
  localparam int BLK_W = $clog2(MAX_BLOCKS);
  localparam int SUM_W = $clog2((1 << LEN_W) + HEADER_BYTES + brmq_pkg::MAX_BLOCK_BYTES);
  localparam int BC_W  = SUM_W - brmq_pkg::LOG2_MIN_I;
  localparam int NUM_W = ((BLK_W > BC_W) ? BLK_W : BC_W) + 1;
  localparam int OW    = ((BC_W > CAP_W) ? BC_W : CAP_W) + 1;
  localparam int DS_W  = END_W + 1;

  function automatic logic [BC_W-1:0] blocks_for(input logic [LEN_W-1:0] n,
                                                 input logic [brmq_pkg::LOG2REG_W-1:0] l);
    logic [SUM_W-1:0] s;
    s = SUM_W'(n) + SUM_W'(HEADER_BYTES) + ((SUM_W'(1) << l) - SUM_W'(1));
    return BC_W'(s >> l);
  endfunction

  function automatic logic [RA_W-1:0] data_start(input logic [BLK_W-1:0] pos,
                                                 input logic [brmq_pkg::LOG2REG_W-1:0] l,
                                                 input logic [END_W-1:0] e);
    logic [DS_W-1:0] s;
    s = (DS_W'(pos) << l) + DS_W'(HEADER_BYTES);
    if (s >= DS_W'(e)) s = s - DS_W'(e);
    if (s >= DS_W'(e)) s = '0;
    return RA_W'(s);
  endfunction

  // byte ring and per-block message lengths
  logic [brmq_pkg::BYTE_W-1:0] ring_mem [RING_BYTES];
  logic [LEN_W-1:0]            len_mem  [MAX_BLOCKS];
  logic [brmq_pkg::BYTE_W-1:0] ring_q;
  logic [LEN_W-1:0]            len_q;
  logic                        ring_we;
  logic                        len_we;

  brmq_pkg::state_t state, state_next;

  // control state
  logic [CAP_W-1:0] occupied, occupied_next;
  logic [BLK_W-1:0] write_block, write_block_next;
  logic [BLK_W-1:0] read_block, read_block_next;
  logic             stopped, stopped_next;
  logic [RA_W-1:0]  send_cursor, send_cursor_next;
  logic [LEN_W-1:0] send_left, send_left_next;
  logic             send_open, send_open_next;
  logic [RA_W-1:0]  recv_cursor, recv_cursor_next;
  logic [LEN_W-1:0] recv_left, recv_left_next;
  logic             recv_open, recv_open_next;
  logic             fin, fin_next;

  // item payload and working values
  brmq_pkg::action_t           act, act_next;
  logic [LEN_W-1:0]            len_r, len_r_next;
  logic [brmq_pkg::BYTE_W-1:0] byte_r, byte_r_next;
  brmq_pkg::status_t           status, status_next;
  logic [brmq_pkg::BYTE_W-1:0] rbyte, rbyte_next;
  logic [brmq_pkg::RLEN_W-1:0] rlen, rlen_next;
  logic                        last, last_next;
  logic [BLK_W-1:0]            blk, blk_next;
  logic [BC_W-1:0]             bc_r, bc_r_next;

  logic             mod_start;
  logic [NUM_W-1:0] mod_x;
  logic             mod_done;
  logic [BLK_W-1:0] mod_r;

  logic [RA_W-1:0]  s_c, s_nx, r_c, r_nx;
  logic [LEN_W-1:0] s_dec, r_dec;
  logic [BC_W-1:0]  bc_in, bc_len;
  logic [OW-1:0]    occ_sum;
  logic             full;
  logic             side_send;

  brmq_mod #(
    .NUM_W(NUM_W),
    .CAP_W(CAP_W),
    .BLK_W(BLK_W)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .x    (mod_x),
    .d    (cap),
    .done (mod_done),
    .r    (mod_r)
  );

  always_comb begin
    s_c  = (END_W'(send_cursor) >= ring_end) ? '0 : send_cursor;
    s_nx = (END_W'(s_c) + END_W'(1) >= ring_end) ? '0 : s_c + RA_W'(1);
    r_c  = (END_W'(recv_cursor) >= ring_end) ? '0 : recv_cursor;
    r_nx = (END_W'(r_c) + END_W'(1) >= ring_end) ? '0 : r_c + RA_W'(1);
    s_dec = (send_left != '0) ? send_left - LEN_W'(1) : '0;
    r_dec = (recv_left != '0) ? recv_left - LEN_W'(1) : '0;
    bc_in  = blocks_for(len_r, lg);
    bc_len = blocks_for(len_q, lg);
    occ_sum = OW'(occupied) + OW'(bc_r);
    full = (OW'(occupied) > OW'(cap)) || (OW'(cap) - OW'(occupied) < OW'(bc_in));
    side_send = (act == brmq_pkg::ACT_OPEN_SEND) || (act == brmq_pkg::ACT_SEND_BYTE);
  end

  always_comb begin
    state_next       = state;
    occupied_next    = occupied;
    write_block_next = write_block;
    read_block_next  = read_block;
    stopped_next     = stopped;
    send_cursor_next = send_cursor;
    send_left_next   = send_left;
    send_open_next   = send_open;
    recv_cursor_next = recv_cursor;
    recv_left_next   = recv_left;
    recv_open_next   = recv_open;
    fin_next         = fin;
    act_next         = act;
    len_r_next       = len_r;
    byte_r_next      = byte_r;
    status_next      = status;
    rbyte_next       = rbyte;
    rlen_next        = rlen;
    last_next        = last;
    blk_next         = blk;
    bc_r_next        = bc_r;
    in_ready         = 1'b0;
    res_load         = 1'b0;
    ring_we          = 1'b0;
    len_we           = 1'b0;
    mod_start        = 1'b0;
    mod_x            = NUM_W'(blk);

    unique case (state)
      brmq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next    = in_action;
          len_r_next  = in_len;
          byte_r_next = in_byte;
          status_next = brmq_pkg::STS_OK;
          rbyte_next  = '0;
          rlen_next   = '0;
          last_next   = 1'b0;
          fin_next    = 1'b0;
          state_next  = brmq_pkg::S_DECODE;
        end
      end

      brmq_pkg::S_DECODE: begin
        state_next = brmq_pkg::S_DONE;
        unique case (act)
          brmq_pkg::ACT_OPEN_SEND: begin
            if (send_open) status_next = brmq_pkg::STS_SEQ_ERR;
            else if (OW'(bc_in) > OW'(cap)) status_next = brmq_pkg::STS_TOO_LARGE;
            else if (stopped) status_next = brmq_pkg::STS_ABORTED;
            else if (full) begin
              status_next = ovf_err ? brmq_pkg::STS_OVERFLOW : brmq_pkg::STS_FULL;
            end else begin
              mod_start  = 1'b1;
              mod_x      = NUM_W'(write_block);
              state_next = brmq_pkg::S_PMOD;
            end
          end
          brmq_pkg::ACT_SEND_BYTE: begin
            if (!send_open) status_next = brmq_pkg::STS_SEQ_ERR;
            else begin
              ring_we          = 1'b1;
              send_cursor_next = s_nx;
              send_left_next   = s_dec;
              if (s_dec == '0) begin
                last_next  = 1'b1;
                fin_next   = 1'b1;
                mod_start  = 1'b1;
                mod_x      = NUM_W'(write_block);
                state_next = brmq_pkg::S_PMOD;
              end
            end
          end
          brmq_pkg::ACT_OPEN_RECV: begin
            if (recv_open) status_next = brmq_pkg::STS_SEQ_ERR;
            else if (stopped) status_next = brmq_pkg::STS_ABORTED;
            else if (occupied == '0) status_next = brmq_pkg::STS_EMPTY;
            else begin
              mod_start  = 1'b1;
              mod_x      = NUM_W'(read_block);
              state_next = brmq_pkg::S_PMOD;
            end
          end
          brmq_pkg::ACT_RECV_BYTE: begin
            if (!recv_open) status_next = brmq_pkg::STS_SEQ_ERR;
            else begin
              recv_cursor_next = r_nx;
              recv_left_next   = r_dec;
              state_next       = brmq_pkg::S_RBYTE;
            end
          end
          brmq_pkg::ACT_CLEAR: begin
            occupied_next    = '0;
            write_block_next = '0;
            read_block_next  = '0;
            send_open_next   = 1'b0;
            send_left_next   = '0;
            send_cursor_next = '0;
            recv_open_next   = 1'b0;
            recv_left_next   = '0;
            recv_cursor_next = '0;
          end
          brmq_pkg::ACT_STOP:   stopped_next = 1'b1;
          brmq_pkg::ACT_RESUME: stopped_next = 1'b0;
          default:              status_next = brmq_pkg::STS_SEQ_ERR;
        endcase
      end

      brmq_pkg::S_RBYTE: begin
        rbyte_next = ring_q;
        state_next = brmq_pkg::S_DONE;
        if (recv_left == '0) begin
          last_next  = 1'b1;
          fin_next   = 1'b1;
          mod_start  = 1'b1;
          mod_x      = NUM_W'(read_block);
          state_next = brmq_pkg::S_PMOD;
        end
      end

      brmq_pkg::S_PMOD: begin
        if (mod_done) begin
          blk_next = mod_r;
          if (!fin && act == brmq_pkg::ACT_OPEN_SEND) begin
            len_we           = 1'b1;
            write_block_next = mod_r;
            send_cursor_next = data_start(mod_r, lg, ring_end);
            send_left_next   = len_r;
            send_open_next   = 1'b1;
            state_next       = brmq_pkg::S_DONE;
            if (len_r == '0) begin
              last_next  = 1'b1;
              fin_next   = 1'b1;
              mod_start  = 1'b1;
              mod_x      = NUM_W'(mod_r);
              state_next = brmq_pkg::S_PMOD;
            end
          end else begin
            if (!fin) read_block_next = mod_r;
            state_next = brmq_pkg::S_LREAD;
          end
        end
      end

      brmq_pkg::S_LREAD: state_next = brmq_pkg::S_LDATA;

      brmq_pkg::S_LDATA: begin
        if (!fin) begin
          recv_left_next   = len_q;
          rlen_next        = len_q[brmq_pkg::RLEN_W-1:0];
          recv_cursor_next = data_start(blk, lg, ring_end);
          recv_open_next   = 1'b1;
          state_next       = brmq_pkg::S_DONE;
          if (len_q == '0) begin
            last_next  = 1'b1;
            fin_next   = 1'b1;
            mod_start  = 1'b1;
            mod_x      = NUM_W'(blk);
            state_next = brmq_pkg::S_PMOD;
          end
        end else begin
          bc_r_next  = bc_len;
          mod_start  = 1'b1;
          mod_x      = NUM_W'(blk) + NUM_W'(bc_len);
          state_next = brmq_pkg::S_QMOD;
        end
      end

      brmq_pkg::S_QMOD: begin
        if (mod_done) begin
          if (side_send) begin
            write_block_next = mod_r;
            occupied_next    = (occ_sum > OW'(cap)) ? cap : CAP_W'(occ_sum);
            send_open_next   = 1'b0;
            send_left_next   = '0;
          end else begin
            read_block_next = mod_r;
            occupied_next   = (OW'(occupied) > OW'(bc_r)) ?
                              CAP_W'(OW'(occupied) - OW'(bc_r)) : '0;
            recv_open_next  = 1'b0;
            recv_left_next  = '0;
          end
          state_next = brmq_pkg::S_DONE;
        end
      end

      brmq_pkg::S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = brmq_pkg::S_IDLE;
        end
      end

      default: state_next = brmq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= brmq_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied    <= '0;
      write_block <= '0;
      read_block  <= '0;
      stopped     <= 1'b0;
      send_cursor <= '0;
      send_left   <= '0;
      send_open   <= 1'b0;
      recv_cursor <= '0;
      recv_left   <= '0;
      recv_open   <= 1'b0;
      fin         <= 1'b0;
    end else begin
      occupied    <= occupied_next;
      write_block <= write_block_next;
      read_block  <= read_block_next;
      stopped     <= stopped_next;
      send_cursor <= send_cursor_next;
      send_left   <= send_left_next;
      send_open   <= send_open_next;
      recv_cursor <= recv_cursor_next;
      recv_left   <= recv_left_next;
      recv_open   <= recv_open_next;
      fin         <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    act    <= act_next;
    len_r  <= len_r_next;
    byte_r <= byte_r_next;
    status <= status_next;
    rbyte  <= rbyte_next;
    rlen   <= rlen_next;
    last   <= last_next;
    blk    <= blk_next;
    bc_r   <= bc_r_next;
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[s_c] <= byte_r;
    ring_q <= ring_mem[r_c];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[mod_r] <= len_r;
    len_q <= len_mem[blk];
  end

  always_comb begin
    res.status      = status;
    res.read_byte   = rbyte;
    res.read_length = rlen;
    res.last_byte   = last;
    res.used_blocks = brmq_pkg::USED_W'(occupied);
  end

endmodule
`default_nettype wire
